/* sv/assert_macros.svh */
// Assertion helpers shared by the conversion modules.
// Every use sits inside a module that has i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* sv/bda_pkg.sv */
package bda_pkg;

    localparam int VALUE_W         = 32;
    localparam int DIGIT_W         = 6;
    localparam int POS_W           = 4;
    // Wide enough for 9 * 10^9 and for 10^10
    localparam int WIDE_W          = 34;
    localparam int MAX_POS         = 9;
    localparam int BDA_QUEUE_DEPTH = 2;

    localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;

    // Conversion job: the value and the decimal position of its leading digit
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
    } t_job;

    // Digit weight table: entry [p][k] is k * 10^p
    typedef logic [MAX_POS:0][MAX_POS:0][WIDE_W-1:0] t_wtab;

    // Power of ten for positions 0 to 10
    function automatic logic [WIDE_W-1:0] pow10(input logic [POS_W-1:0] p);
        logic [WIDE_W-1:0] r;
        case (p)
            4'd0:    r = 34'd1;
            4'd1:    r = 34'd10;
            4'd2:    r = 34'd100;
            4'd3:    r = 34'd1000;
            4'd4:    r = 34'd10000;
            4'd5:    r = 34'd100000;
            4'd6:    r = 34'd1000000;
            4'd7:    r = 34'd10000000;
            4'd8:    r = 34'd100000000;
            4'd9:    r = 34'd1000000000;
            4'd10:   r = 34'd10000000000;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Build the weight table at elaboration
    function automatic t_wtab build_weights();
        t_wtab w;
        w = '0;
        for (int p = 0; p <= MAX_POS; p++) begin
            for (int k = 0; k <= MAX_POS; k++) begin
                w[p][k] = WIDE_W'(pow10(POS_W'(p)) * k);
            end
        end
        return w;
    endfunction

    localparam t_wtab WEIGHT = build_weights();

endpackage

/* sv/bda_front.sv */
`include "assert_macros.svh"

module bda_front
    import bda_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_full,
    output logic               o_push,
    output t_job               o_job
);

    logic             r_valid;
    t_job             r_job;
    logic [POS_W-1:0] lead_pos;
    logic             accept;

    // Find the leading digit position: count the powers of ten from 10 to 10^9 not above the value
    always_comb begin
        lead_pos = '0;
        for (int i = 1; i <= MAX_POS; i++) begin
            lead_pos = lead_pos +
                POS_W'({2'b00, i_value} >= pow10(POS_W'(i)));
        end
    end

    // Stall the input during reset and while the held transaction cannot move on
    assign o_stall = !i_rst_n || (r_valid && i_full);
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_job   = r_job;

    // Hold a classified transaction until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job.value <= i_value;
            r_job.pos   <= lead_pos;
        end
    end

    `ASSERT_PROP(a_front_lead_pos, r_valid |-> (({2'b00, r_job.value} < pow10(r_job.pos + 4'd1)) && (r_job.pos == '0 || {2'b00, r_job.value} >= pow10(r_job.pos))), "leading digit position does not match value")

endmodule

/* sv/bda_fifo.sv */
`include "assert_macros.svh"

module bda_fifo
    import bda_pkg::*;
#(
    parameter int DEPTH = BDA_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `ASSERT_NEVER(a_fifo_overflow, i_push && o_full, "push into full queue")
    `ASSERT_NEVER(a_fifo_underflow, i_pop && o_empty, "pop from empty queue")

endmodule

/* sv/bda_back.sv */
`include "assert_macros.svh"

module bda_back
    import bda_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [DIGIT_W-1:0] o_digit_char,
    output logic               o_last
);

    logic               r_busy;
    logic [VALUE_W-1:0] r_rem;
    logic [POS_W-1:0]   r_pos;
    logic               r_out_valid;
    logic [DIGIT_W-1:0] r_digit;
    logic               r_last;

    logic [WIDE_W-1:0]  diff;
    logic [POS_W-1:0]   step_digit;
    logic [VALUE_W-1:0] step_rem;
    logic               adv;
    logic               final_digit;

    // Extract the current digit: largest k with k * 10^pos not above the remainder
    always_comb begin
        step_digit = '0;
        step_rem   = r_rem;
        diff       = '0;
        for (int k = 1; k <= MAX_POS; k++) begin
            diff = {2'b00, r_rem} - WEIGHT[r_pos][k];
            if (!diff[WIDE_W-1]) begin
                step_digit = POS_W'(k);
                step_rem   = diff[VALUE_W-1:0];
            end
        end
    end

    assign adv         = r_busy && (!r_out_valid || !i_stall);
    assign final_digit = (r_pos == '0);
    assign o_pop       = !i_empty && (!r_busy || (adv && final_digit));

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_digit;
    assign o_last       = r_last;

    // Track the active job and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (adv && final_digit) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load a new job or step one digit down
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem <= i_job.value;
            r_pos <= i_job.pos;
        end else if (adv) begin
            r_rem <= step_rem;
            r_pos <= r_pos - 1'b1;
        end
        if (adv) begin
            r_digit <= ASCII_ZERO + DIGIT_W'(step_digit);
            r_last  <= final_digit;
        end
    end

    `ASSERT_PROP(a_back_digit_range, r_out_valid |-> (r_digit >= ASCII_ZERO && r_digit <= ASCII_ZERO + 6'd9), "digit character out of range")
    `ASSERT_PROP(a_back_job_done, (adv && final_digit && !o_pop) |=> !r_busy, "job still active after last digit")
    `ASSERT_PROP(a_back_last_clears, (adv && !final_digit) |=> (r_busy && r_pos == $past(r_pos) - 4'd1), "position did not step down")

endmodule

/* sv/binary_to_decimal_ascii.sv */
// Binary to decimal ASCII converter. Each accepted transaction carries one
// 32-bit unsigned value; the block returns its decimal digits as ASCII codes
// (6 bits, '0' to '9'), most significant first, without leading zeros, with
// o_last set on the final digit. Zero gives a single '0'. A value with n (1 to
// 10) decimal digits yields n output transactions, one per cycle while i_stall
// is low, and holds the digit unit until its final digit; that unit extracts
// one digit per cycle unless stalled, comparing the remainder with the nine
// multiples of the current power of ten. A front stage finds the leading digit
// position and feeds a short job queue, so input and output stall independently
// and new values are accepted while earlier ones are still being emitted.
// Values pass the front register and the job queue before the digit unit.
module binary_to_decimal_ascii
    import bda_pkg::*;
#(
    parameter int QUEUE_DEPTH = BDA_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [DIGIT_W-1:0] o_digit_char,
    output logic               o_last
);

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_job front_job;
    t_job queue_job;

    bda_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    bda_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (queue_job)
    );

    bda_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_job        (queue_job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule
